[hw/rtl/cbts_pkg.sv]
// ============================================================================
// CAN bit timing solver package
// Shared constants, result codes and field widths for the bit timing solver.
// ============================================================================
package cbts_pkg;

	// Field widths.
	localparam int CLOCK_W   = 30;
	localparam int RATE_W    = 23;
	localparam int STATUS_W  = 3;
	localparam int PRESC_W   = 8;
	localparam int SJW_W     = 2;
	localparam int TS1_W     = 4;
	localparam int TS2_W     = 3;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	// Default segment and prescaler limits.
	localparam int MAX_TS1_DEF       = 16;
	localparam int MAX_TS2_DEF       = 8;
	localparam int MAX_PRESCALER_DEF = 256;

	// Solver constants.
	localparam logic [CLOCK_W-1:0] CLOCK_RESET = 30'd24000000;
	localparam logic [RATE_W-1:0]  RATE_MIN    = 23'd1000;
	localparam logic [RATE_W-1:0]  RATE_FAST   = 23'd1000000;
	localparam logic [4:0]         QMAX_FAST   = 5'd10;
	localparam logic [4:0]         QMAX_SLOW   = 5'd17;
	localparam int                 SP_LIMIT    = 900;
	localparam int                 SP_SCALE    = 1000;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RATE_LOW  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_DIV    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PRESC     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_SPLIT  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd5;

endpackage

[hw/rtl/can_bit_timing_solver_top.sv]
// ============================================================================
// CAN bit timing solver
// Solves prescaler and segment codes for a requested bitrate on one shared
// restoring divider under a small sequencer.
// ============================================================================
// Each request on the slave side carries a bitrate; one result follows on the
// master side. The block works through a request in these steps, its divisions all on the
// same one-bit-per-cycle divider:
// - take the request;
// - a division for clock/bitrate, which is 30 divider steps and one
//   step that uses the result;
// - another such division for every quanta count tried, up to fifteen;
// - the segment split;
// - a final division that checks the bitrate;
// - load the result.
// A count of three never reaches the final check. Requests below 1000 bit/s
// go straight from taking the request to loading the result. The block takes
// no new request while it works, but takes one while a result still waits in
// the output register. Loading the result waits for as long as that earlier
// result is not taken. The clock register may only be written while the
// block is idle.
module can_bit_timing_solver_top
	import cbts_pkg::*;
#(
	parameter int MAX_TS1       = MAX_TS1_DEF,
	parameter int MAX_TS2       = MAX_TS2_DEF,
	parameter int MAX_PRESCALER = MAX_PRESCALER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CLOCK_W-1:0]    cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [22:0] bitrate, [23] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [2:0] status, [10:3] prescaler_code, [12:11] sjw_code,
	// [16:13] ts1_code, [19:17] ts2_code, [23:20] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_POST, S_SPLIT, S_DONE} state_t;
	typedef enum logic [1:0] {OP_PBS, OP_TRIAL, OP_CHECK} op_t;

	localparam logic [5:0]         TS_SUM_LIM = 6'(MAX_TS1 + MAX_TS2);
	localparam logic [4:0]         TS1_LIM    = 5'(MAX_TS1);
	localparam logic [4:0]         TS2_LIM    = 5'(MAX_TS2);
	localparam logic [CLOCK_W-1:0] PRESC_LIM  = CLOCK_W'(MAX_PRESCALER);
	localparam logic [14:0]        SP_MUL     = 15'(SP_SCALE);
	localparam logic [14:0]        SP_BOUND   = 15'(SP_LIMIT + 1);
	localparam logic [4:0]         DIV_LAST   = 5'(CLOCK_W - 1);

	state_t                state_q;
	op_t                   op_q;
	logic [CLOCK_W-1:0]    clock_q;
	logic [RATE_W-1:0]     bitrate_q;
	logic [CLOCK_W-1:0]    pbs_q;
	logic [CLOCK_W-1:0]    presc_q;
	logic [4:0]            sum_q;
	logic [4:0]            bs1_q;
	logic [4:0]            bs2_q;
	logic [STATUS_W-1:0]   status_q;
	logic [PRESC_W-1:0]    held_presc_q;
	logic [SJW_W-1:0]      held_sjw_q;
	logic [TS1_W-1:0]      held_ts1_q;
	logic [TS2_W-1:0]      held_ts2_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	// Divider registers: the dividend shifts out as quotient bits shift in.
	logic [CLOCK_W-1:0]    div_num_q;
	logic [CLOCK_W-1:0]    div_den_q;
	logic [CLOCK_W-1:0]    div_rem_q;
	logic [4:0]            div_cnt_q;

	logic [CLOCK_W:0]      div_shift;
	logic [CLOCK_W:0]      div_diff;
	logic                  div_fit;
	logic [RATE_W-1:0]     in_rate;
	logic [4:0]            in_maxq;
	logic [6:0]            sum7;
	logic [4:0]            bs1_rnd;
	logic [4:0]            bs1_trn;
	logic [4:0]            bs1_fin;
	logic [4:0]            bs2_fin;
	logic                  sp_high;
	logic                  seg_ok;
	logic                  presc_ok;
	logic                  out_free;
	logic                  done_fire;
	logic [PRESC_W-1:0]    new_presc;
	logic [SJW_W-1:0]      new_sjw;
	logic [TS1_W-1:0]      new_ts1;
	logic [TS2_W-1:0]      new_ts2;

	// One restoring division step.
	always_comb begin
		div_shift = {div_rem_q, div_num_q[CLOCK_W-1]};
		div_diff  = div_shift - {1'b0, div_den_q};
		div_fit   = div_shift >= {1'b0, div_den_q};
	end

	// Request decode: the largest quanta count depends on the rate band.
	always_comb begin
		in_rate = s_axis_tdata[RATE_W-1:0];
		in_maxq = (in_rate >= RATE_FAST) ? QMAX_FAST : QMAX_SLOW;
	end

	// Segment split aiming at an 87.5 % sample point, truncated above 90 %.
	always_comb begin
		sum7     = 7'(sum_q) * 7'd7;
		bs1_rnd  = 5'((sum7 + 7'd3) >> 3);
		bs1_trn  = 5'((sum7 - 7'd1) >> 3);
		sp_high  = (SP_MUL * (15'(bs1_rnd) + 15'd1)) >= (SP_BOUND * (15'(sum_q) + 15'd1));
		bs1_fin  = sp_high ? bs1_trn : bs1_rnd;
		bs2_fin  = sum_q - bs1_fin;
		seg_ok   = (bs1_fin != 5'd0) && (bs1_fin <= TS1_LIM) &&
		           (bs2_fin != 5'd0) && (bs2_fin <= TS2_LIM);
		presc_ok = (presc_q != '0) && (presc_q <= PRESC_LIM);
	end

	// Held codes after this request: replaced on success only.
	always_comb begin
		out_free  = !m_valid_q || m_axis_tready;
		done_fire = (state_q == S_DONE) && out_free;
		if (status_q == ST_OK) begin
			new_presc = presc_q[PRESC_W-1:0] - 8'd1;
			new_sjw   = 2'd1;
			new_ts1   = bs1_q[TS1_W-1:0] - 4'd1;
			new_ts2   = bs2_q[TS2_W-1:0] - 3'd1;
		end else begin
			new_presc = held_presc_q;
			new_sjw   = held_sjw_q;
			new_ts1   = held_ts1_q;
			new_ts2   = held_ts2_q;
		end
	end

	// Sequencer, divider, held codes and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_PBS;
			clock_q      <= CLOCK_RESET;
			bitrate_q    <= '0;
			pbs_q        <= '0;
			presc_q      <= '0;
			sum_q        <= '0;
			bs1_q        <= '0;
			bs2_q        <= '0;
			status_q     <= ST_OK;
			held_presc_q <= '0;
			held_sjw_q   <= '0;
			held_ts1_q   <= '0;
			held_ts2_q   <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			div_rem_q    <= '0;
			div_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				clock_q <= cfg_wdata;
			end
			// A new result takes the output register as the old one leaves.
			if (done_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						bitrate_q <= in_rate;
						sum_q     <= in_maxq - 5'd1;
						if (in_rate < RATE_MIN) begin
							status_q <= ST_RATE_LOW;
							state_q  <= S_DONE;
						end else if (6'(in_maxq) > TS_SUM_LIM) begin
							status_q <= ST_NO_SPLIT;
							state_q  <= S_DONE;
						end else begin
							// Start clock / bitrate.
							op_q      <= OP_PBS;
							div_num_q <= clock_q;
							div_den_q <= CLOCK_W'(in_rate);
							div_rem_q <= '0;
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
					end
				end

				S_DIV: begin
					div_rem_q <= div_fit ? div_diff[CLOCK_W-1:0] : div_shift[CLOCK_W-1:0];
					div_num_q <= {div_num_q[CLOCK_W-2:0], div_fit};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_POST;
					end
				end

				S_POST: begin
					div_rem_q <= '0;
					div_cnt_q <= '0;
					case (op_q)
						OP_PBS: begin
							// First trial divides by the largest quanta count.
							pbs_q     <= div_num_q;
							div_num_q <= div_num_q;
							div_den_q <= CLOCK_W'(sum_q) + 30'd1;
							op_q      <= OP_TRIAL;
							state_q   <= S_DIV;
						end
						OP_TRIAL: begin
							if (div_rem_q == '0) begin
								presc_q <= div_num_q;
								state_q <= S_SPLIT;
							end else if (sum_q <= 5'd2) begin
								status_q <= ST_NO_DIV;
								state_q  <= S_DONE;
							end else begin
								// One quanta fewer: the new count equals the old sum.
								sum_q     <= sum_q - 5'd1;
								div_num_q <= pbs_q;
								div_den_q <= CLOCK_W'(sum_q);
								state_q   <= S_DIV;
							end
						end
						OP_CHECK: begin
							status_q <= (div_num_q == CLOCK_W'(bitrate_q)) ? ST_OK : ST_MISMATCH;
							state_q  <= S_DONE;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				S_SPLIT: begin
					bs1_q <= bs1_fin;
					bs2_q <= bs2_fin;
					if (!presc_ok) begin
						status_q <= ST_PRESC;
						state_q  <= S_DONE;
					end else if (sum_q <= bs1_rnd) begin
						status_q <= ST_NO_SPLIT;
						state_q  <= S_DONE;
					end else if (!seg_ok) begin
						status_q <= ST_MISMATCH;
						state_q  <= S_DONE;
					end else begin
						// The bit length in clocks is pbs exactly, so check clock / pbs.
						op_q      <= OP_CHECK;
						div_num_q <= clock_q;
						div_den_q <= pbs_q;
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end

				S_DONE: begin
					if (out_free) begin
						held_presc_q <= new_presc;
						held_sjw_q   <= new_sjw;
						held_ts1_q   <= new_ts1;
						held_ts2_q   <= new_ts2;
						m_data_q     <= {4'b0000, new_ts2, new_ts1, new_sjw, new_presc, status_q};
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[hw/rtl/cbts_checker.sv]
// ============================================================================
// CAN bit timing solver checker
// Port-level assertions on the solver, attached to the top level by bind.
// ============================================================================
module cbts_checker
	import cbts_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [16:0]         last_codes_q;
	logic [STATUS_W-1:0] out_status;
	logic                out_take;

	assign out_status = m_axis_tdata[2:0];
	assign out_take   = m_axis_tvalid && m_axis_tready;

	// Codes of the last delivered result; they start as the reset codes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_codes_q <= '0;
		end else if (out_take) begin
			last_codes_q <= m_axis_tdata[19:3];
		end
	end

	// The solver is not ready in the cycle after it takes a request.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("solver ready straight after a request");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_status <= ST_MISMATCH)
		else $error("undefined status code");

	// A failed request leaves the codes as the previous result left them.
	a_fail_keeps_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_status != ST_OK |-> m_axis_tdata[19:3] == last_codes_q)
		else $error("codes changed on a failed request");

	// Success always programs a sync jump width code of one.
	a_ok_sjw: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_status == ST_OK |-> m_axis_tdata[12:11] == 2'd1)
		else $error("sync jump width not one on success");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind can_bit_timing_solver_top cbts_checker u_cbts_checker (.*);

[sim/can_timing_checker.sv]
// ============================================================================
// CAN bit timing checker
// Watches the configuration port and both stream channels of the bit timing
// solver. It keeps its own copy of the clock register and the held codes,
// works out the result of every accepted request, and compares every
// accepted result field by field with the oldest outstanding prediction.
// ============================================================================
module can_timing_checker
	import cbts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CLOCK_W-1:0]    cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// [22:0] bitrate, [23] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] status, [10:3] prescaler_code, [12:11] sjw_code,
	// [16:13] ts1_code, [19:17] ts2_code, [23:20] zero
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result word, status in the lowest bits as on the bus.
	typedef struct packed {
		logic [TS2_W-1:0]    ts2;
		logic [TS1_W-1:0]    ts1;
		logic [SJW_W-1:0]    sjw;
		logic [PRESC_W-1:0]  presc;
		logic [STATUS_W-1:0] status;
	} timing_t;

	localparam int TIMING_W = $bits(timing_t);

	logic [CLOCK_W-1:0] clock_hz;
	logic [PRESC_W-1:0] held_presc;
	logic [SJW_W-1:0]   held_sjw;
	logic [TS1_W-1:0]   held_ts1;
	logic [TS2_W-1:0]   held_ts2;
	timing_t            pending_timings[$];
	timing_t            want;
	timing_t            got;

	// Solve one request against the current clock; a success loads the held
	// codes, and every result reports the held codes as they then stand.
	function automatic timing_t solve_timing(input logic [RATE_W-1:0] rate);
		int unsigned         r;
		int unsigned         per_bit;
		int unsigned         qsum;
		int unsigned         presc;
		int unsigned         bs1;
		int unsigned         bs2;
		int unsigned         sp;
		logic [STATUS_W-1:0] st;
		timing_t             res;
		r       = 32'(rate);
		st      = ST_OK;
		per_bit = 0;
		qsum    = 0;
		presc   = 0;
		bs1     = 0;
		bs2     = 0;
		sp      = 0;
		if (r < RATE_MIN) begin
			st = ST_RATE_LOW;
		end else begin
			qsum = ((r >= RATE_FAST) ? QMAX_FAST : QMAX_SLOW) - 1;
			if (qsum + 1 > MAX_TS1_DEF + MAX_TS2_DEF)
				st = ST_NO_SPLIT;
		end
		// Walk the quanta count down until it divides clock/bitrate.
		if (st == ST_OK) begin
			per_bit = clock_hz / r;
			while (st == ST_OK && (per_bit % (qsum + 1)) != 0) begin
				if (qsum <= 2)
					st = ST_NO_DIV;
				else
					qsum = qsum - 1;
			end
		end
		if (st == ST_OK) begin
			presc = per_bit / (qsum + 1);
			if (presc < 1 || presc > MAX_PRESCALER_DEF)
				st = ST_PRESC;
		end
		// Rounded split first; truncated when the sample point lands past 90%.
		if (st == ST_OK) begin
			bs1 = (7 * qsum + 3) / 8;
			if (qsum <= bs1)
				st = ST_NO_SPLIT;
		end
		if (st == ST_OK) begin
			bs2 = qsum - bs1;
			sp  = (SP_SCALE * (1 + bs1)) / (1 + qsum);
			if (sp > SP_LIMIT) begin
				bs1 = (7 * qsum - 1) / 8;
				bs2 = qsum - bs1;
			end
			if (bs1 < 1 || bs1 > MAX_TS1_DEF || bs2 < 1 || bs2 > MAX_TS2_DEF ||
			    r != clock_hz / (presc * (1 + bs1 + bs2)))
				st = ST_MISMATCH;
		end
		if (st == ST_OK) begin
			held_presc = PRESC_W'(presc - 1);
			held_sjw   = SJW_W'(1);
			held_ts1   = TS1_W'(bs1 - 1);
			held_ts2   = TS2_W'(bs2 - 1);
		end
		res.status = st;
		res.presc  = held_presc;
		res.sjw    = held_sjw;
		res.ts1    = held_ts1;
		res.ts2    = held_ts2;
		return res;
	endfunction

	// Report one field and return 1 when it differs.
	function automatic int unsigned field_error(input string label, input int unsigned exp_val,
	                                            input int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			         $time, label, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	// Sample mid-cycle; a handshake seen here completes at the next rising
	// edge. Results are checked before the new request is predicted, since a
	// result can never belong to a request accepted at the same edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			clock_hz   = CLOCK_RESET;
			held_presc = '0;
			held_sjw   = '0;
			held_ts1   = '0;
			held_ts2   = '0;
			mismatches = 0;
			pending_timings.delete();
		end else begin
			if (cfg_we === 1'b1)
				clock_hz = cfg_wdata;
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got = m_tdata[TIMING_W-1:0];
				if (pending_timings.size() == 0) begin
					$display("%0t ns: result with no request outstanding, expected none, actual %h",
					         $time, m_tdata);
					mismatches = mismatches + 1;
				end else begin
					want = pending_timings.pop_front();
					mismatches = mismatches
						+ field_error("status", 32'(want.status), 32'(got.status))
						+ field_error("prescaler_code", 32'(want.presc), 32'(got.presc))
						+ field_error("sjw_code", 32'(want.sjw), 32'(got.sjw))
						+ field_error("ts1_code", 32'(want.ts1), 32'(got.ts1))
						+ field_error("ts2_code", 32'(want.ts2), 32'(got.ts2))
						+ field_error("padding", 0, 32'(m_tdata[OUT_DATA_W-1:TIMING_W]));
				end
			end
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				pending_timings.push_back(solve_timing(s_tdata[RATE_W-1:0]));
		end
		outstanding = pending_timings.size();
	end

endmodule

[sim/tb_can_bit_timing_solver_top.sv]
// ============================================================================
// CAN bit timing solver testbench
// Drives bitrate requests and clock settings into the solver, with phases of
// sender gaps and receiver stalls and one long receiver hold-off. The checker
// beside the block predicts and compares every result; this module only
// makes stimulus and gives the verdict.
// ============================================================================
module tb_can_bit_timing_solver_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cbts_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 20000;
	localparam int unsigned HOLD_OFF_CYCLES = 3000;
	localparam int unsigned DRAIN_CYCLES    = 600;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned PHASE_ITEMS     = 125;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CLOCK_W-1:0]    cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int unsigned        send_idle_pct  = 0;
	int unsigned        recv_stall_pct = 0;
	bit                 hold_off_req   = 1'b0;
	int unsigned        quiet_cycles   = 0;
	int unsigned        mismatches;
	int unsigned        outstanding;
	logic [CLOCK_W-1:0] clock_setting  = CLOCK_RESET;

	// Directed requests at the reset clock of 24 MHz.
	int unsigned directed_rates[$] = '{
		0, 7, 999,            // below the minimum rate
		1000, 8000000,        // minimum rate, and 8 Mbit/s
		4194304,              // top bit of the field
		999999, 1000000,      // either side of the fast-rate quanta limit
		5859,                 // prescaler of exactly 256
		5000,                 // prescaler above 256
		1043478,              // no quanta count divides
		1100000,              // divides, but the rate is not exact
		727272,               // sample point past 90%, truncated split
		6000000,              // four quanta leave no split
		1001, 10000, 125000, 250000, 500000, 1200000, 1
	};

	can_bit_timing_solver_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	can_timing_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 100 MHz clock.
	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// Offer one request, after random gaps, and return at the accepting edge.
	task automatic send_rate(input int unsigned rate);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			if ($urandom_range(99) < 3)
				repeat ($urandom_range(700, 1)) @(posedge clk);
			else
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'(rate[RATE_W-1:0]);
		@(negedge clk);
		while (s_axis_tready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Let every outstanding result drain, then load a new clock.
	task automatic write_clock(input logic [CLOCK_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		cfg_we        <= 1'b1;
		cfg_wdata     <= value;
		clock_setting  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly rates built from a prescaler and a quanta count so that the
	// solver gets through to the split and the final check; the rest are
	// common bus rates, arbitrary rates and rates near the lower limit.
	function automatic int unsigned pick_rate();
		int unsigned kind;
		int unsigned presc;
		int unsigned quanta;
		int unsigned cand;
		int unsigned rate;
		int unsigned tries;
		bit          found;
		kind  = $urandom_range(99);
		rate  = $urandom_range(8000000, 0);
		found = 1'b0;
		if (kind < 55) begin
			for (tries = 0; tries < 8 && !found; tries++) begin
				presc  = ($urandom_range(3) == 0) ? $urandom_range(256, 1) : $urandom_range(16, 1);
				quanta = $urandom_range(17, 3);
				cand   = clock_setting / (presc * quanta);
				if (cand >= 1000 && cand <= 8000000) begin
					rate  = cand;
					found = 1'b1;
				end
			end
			// An occasional near miss exercises the exactness check.
			if (found && $urandom_range(9) == 0)
				rate = rate - 1;
		end else if (kind < 70) begin
			case ($urandom_range(8))
				0:       rate = 10000;
				1:       rate = 20000;
				2:       rate = 50000;
				3:       rate = 100000;
				4:       rate = 125000;
				5:       rate = 250000;
				6:       rate = 500000;
				7:       rate = 800000;
				default: rate = 1000000;
			endcase
		end else if (kind >= 90) begin
			rate = $urandom_range(1100, 0);
		end
		return rate;
	endfunction

	// Receiver: random stalls, and one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				hold_off_req   = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles with nothing accepted.
	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Main stimulus.
	initial begin
		int unsigned phase;
		int unsigned n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rates[i])
			send_rate(directed_rates[i]);

		// Clock below every bitrate, then the fastest clock.
		write_clock(CLOCK_W'(1));
		send_rate(1000);
		send_rate(8000000);
		write_clock(CLOCK_W'(1000000000));
		send_rate(1000);
		send_rate(8000000);

		// Random phases, one clock setting and one idling mode each.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       write_clock(CLOCK_W'(8000000));
				1:       write_clock(CLOCK_W'(16000000));
				2:       write_clock(CLOCK_W'(40000000));
				3:       write_clock(CLOCK_W'(48000000));
				4:       write_clock(CLOCK_W'(80000000));
				5:       write_clock(CLOCK_W'(1000000000));
				6:       write_clock(CLOCK_W'(36000000));
				default: write_clock(CLOCK_W'($urandom_range(1000000000, 1)));
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct  = 31;
					recv_stall_pct = 31;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == 10)
					hold_off_req = 1'b1;
				send_rate(pick_rate());
			end
		end

		// Drain and settle, then give the verdict.
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
